@@ design/s256c_pkg.sv @@
// ----------------------------------------------------------------------------
// s256c_pkg - shared types and constants for the SHA-256 block compressor
// Word types, the packed input and result words, and the round constants.
// ----------------------------------------------------------------------------
package s256c_pkg;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned SCHED_WORDS = 16;
  localparam int unsigned STATE_WORDS = 8;

  typedef logic [31:0] word_t;
  typedef logic [STATE_WORDS-1:0][31:0] state_t;  // index 0 = A ... 7 = H
  typedef logic [SCHED_WORDS-1:0][31:0] sched_t;  // index 0 = word used now

  typedef struct packed {
    logic [63:0] chain_ab;
    logic [63:0] chain_cd;
    logic [63:0] chain_ef;
    logic [63:0] chain_gh;
    logic [63:0] msg_w0_w1;
    logic [63:0] msg_w2_w3;
    logic [63:0] msg_w4_w5;
    logic [63:0] msg_w6_w7;
    logic [63:0] msg_w8_w9;
    logic [63:0] msg_w10_w11;
    logic [63:0] msg_w12_w13;
    logic [63:0] msg_w14_w15;
  } in_word_t;

  typedef struct packed {
    logic [63:0] new_ab;
    logic [63:0] new_cd;
    logic [63:0] new_ef;
    logic [63:0] new_gh;
  } out_word_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ design/s256c_round_cell.sv @@
// ----------------------------------------------------------------------------
// s256c_round_cell - one SHA-256 round stage
// Runs one round on the working state, slides the 16-word schedule window
// by one word and registers everything for the next cell.
// ----------------------------------------------------------------------------
module s256c_round_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  s256c_pkg::state_t in_state,
  input  s256c_pkg::state_t in_chain,
  input  s256c_pkg::sched_t in_sched,
  input  s256c_pkg::word_t  k,
  output logic              out_valid,
  output s256c_pkg::state_t out_state,
  output s256c_pkg::state_t out_chain,
  output s256c_pkg::sched_t out_sched
);

  function automatic s256c_pkg::word_t big_sigma0(input s256c_pkg::word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic s256c_pkg::word_t big_sigma1(input s256c_pkg::word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic s256c_pkg::word_t small_sigma0(input s256c_pkg::word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic s256c_pkg::word_t small_sigma1(input s256c_pkg::word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  s256c_pkg::word_t  t1;
  s256c_pkg::word_t  t2;
  s256c_pkg::word_t  choose;
  s256c_pkg::word_t  major;
  s256c_pkg::state_t state_next;
  s256c_pkg::sched_t sched_next;

  always_comb begin
    choose = (in_state[4] & in_state[5]) ^ (~in_state[4] & in_state[6]);
    major  = (in_state[0] & in_state[1]) ^ (in_state[0] & in_state[2]) ^
             (in_state[1] & in_state[2]);
    t1 = in_state[7] + big_sigma1(in_state[4]) + choose + k + in_sched[0];
    t2 = big_sigma0(in_state[0]) + major;

    state_next[0] = t1 + t2;
    state_next[1] = in_state[0];
    state_next[2] = in_state[1];
    state_next[3] = in_state[2];
    state_next[4] = in_state[3] + t1;
    state_next[5] = in_state[4];
    state_next[6] = in_state[5];
    state_next[7] = in_state[6];

    // window slides down; new word is W[i+16]
    for (int j = 0; j < 15; j++) begin
      sched_next[j] = in_sched[j+1];
    end
    sched_next[15] = in_sched[0] + small_sigma0(in_sched[1]) + in_sched[9] +
                     small_sigma1(in_sched[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_state <= state_next;
    out_chain <= in_chain;
    out_sched <= sched_next;
  end

endmodule

@@ design/s256c_finalize.sv @@
// ----------------------------------------------------------------------------
// s256c_finalize - chaining value feed-forward
// Adds the saved chaining words to the state after the last round and
// packs the result word.
// ----------------------------------------------------------------------------
module s256c_finalize (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  s256c_pkg::state_t    in_state,
  input  s256c_pkg::state_t    in_chain,
  output logic                 done,
  output s256c_pkg::out_word_t result
);

  s256c_pkg::state_t sum;

  always_comb begin
    for (int j = 0; j < s256c_pkg::STATE_WORDS; j++) begin
      sum[j] = in_chain[j] + in_state[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    result.new_ab <= {sum[0], sum[1]};
    result.new_cd <= {sum[2], sum[3]};
    result.new_ef <= {sum[4], sum[5]};
    result.new_gh <= {sum[6], sum[7]};
  end

endmodule

@@ design/sha256_block_compress.sv @@
// ----------------------------------------------------------------------------
// sha256_block_compress - fully unrolled SHA-256 compression pipeline
// Pipeline: round cell 0 captures a word at the edge that accepts it; the word then
//   passes through the 64 round cells and the feed-forward add in finalize, which
//   raises done with the result.
// Throughput: one block per cycle; busy is never asserted, and the result
//   side cannot stall, so words flow straight through.
// Reset: rst (synchronous) clears the valid bits of every cell and done;
//   words in flight are dropped. Data registers are not reset.
// ----------------------------------------------------------------------------
module sha256_block_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  s256c_pkg::in_word_t  blk,
  output logic                 done,
  output s256c_pkg::out_word_t result
);

  localparam int unsigned LATENCY = s256c_pkg::ROUNDS + 1;

  // Stage j holds the inputs of round cell j; stage ROUNDS feeds finalize.
  logic              stage_valid [s256c_pkg::ROUNDS+1];
  s256c_pkg::state_t stage_state [s256c_pkg::ROUNDS+1];
  s256c_pkg::state_t stage_chain [s256c_pkg::ROUNDS+1];
  s256c_pkg::sched_t stage_sched [s256c_pkg::ROUNDS+1];

  // Nothing ever holds the pipeline back.
  assign busy = 1'b0;

  // Unpack the incoming word: earlier word of each pair in the high half.
  always_comb begin
    stage_valid[0] = start && !busy;

    stage_chain[0][0] = blk.chain_ab[63:32];
    stage_chain[0][1] = blk.chain_ab[31:0];
    stage_chain[0][2] = blk.chain_cd[63:32];
    stage_chain[0][3] = blk.chain_cd[31:0];
    stage_chain[0][4] = blk.chain_ef[63:32];
    stage_chain[0][5] = blk.chain_ef[31:0];
    stage_chain[0][6] = blk.chain_gh[63:32];
    stage_chain[0][7] = blk.chain_gh[31:0];

    // working state starts as the chaining value
    stage_state[0] = stage_chain[0];

    stage_sched[0][0]  = blk.msg_w0_w1[63:32];
    stage_sched[0][1]  = blk.msg_w0_w1[31:0];
    stage_sched[0][2]  = blk.msg_w2_w3[63:32];
    stage_sched[0][3]  = blk.msg_w2_w3[31:0];
    stage_sched[0][4]  = blk.msg_w4_w5[63:32];
    stage_sched[0][5]  = blk.msg_w4_w5[31:0];
    stage_sched[0][6]  = blk.msg_w6_w7[63:32];
    stage_sched[0][7]  = blk.msg_w6_w7[31:0];
    stage_sched[0][8]  = blk.msg_w8_w9[63:32];
    stage_sched[0][9]  = blk.msg_w8_w9[31:0];
    stage_sched[0][10] = blk.msg_w10_w11[63:32];
    stage_sched[0][11] = blk.msg_w10_w11[31:0];
    stage_sched[0][12] = blk.msg_w12_w13[63:32];
    stage_sched[0][13] = blk.msg_w12_w13[31:0];
    stage_sched[0][14] = blk.msg_w14_w15[63:32];
    stage_sched[0][15] = blk.msg_w14_w15[31:0];
  end

  // Chain of round cells. Each one carries the chaining value along so the
  // feed-forward add at the end sees the value that entered with the block.
  // The schedule words produced by the last sixteen cells are never used.
  for (genvar r = 0; r < s256c_pkg::ROUNDS; r++) begin : g_round
    s256c_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r]),
      .in_state  (stage_state[r]),
      .in_chain  (stage_chain[r]),
      .in_sched  (stage_sched[r]),
      .k         (s256c_pkg::ROUND_K[r]),
      .out_valid (stage_valid[r+1]),
      .out_state (stage_state[r+1]),
      .out_chain (stage_chain[r+1]),
      .out_sched (stage_sched[r+1])
    );
  end

  s256c_finalize u_finalize (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[s256c_pkg::ROUNDS]),
    .in_state (stage_state[s256c_pkg::ROUNDS]),
    .in_chain (stage_chain[s256c_pkg::ROUNDS]),
    .done     (done),
    .result   (result)
  );

  // A result only ever comes from an accepted word that has passed the whole pipeline.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("done without a matching accepted word");

  // The last round stage always reaches the result port in the cycle after.
  a_last_to_done: assert property (@(posedge clk) disable iff (rst)
    stage_valid[s256c_pkg::ROUNDS] |=> done)
    else $error("last round word lost before done");

  // A word in the middle of the chain moves exactly one cell per cycle.
  a_mid_advance: assert property (@(posedge clk) disable iff (rst)
    stage_valid[s256c_pkg::ROUNDS/2] |=> stage_valid[s256c_pkg::ROUNDS/2 + 1])
    else $error("word stalled inside the round chain");

endmodule
